// ----- rtl/bcsh_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit crusher sample-and-hold package
// Shared widths, register indexes, reset values, the lane control struct and
// the round-and-saturate helper used by the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package bcsh_pkg;

   // Default channel count of the top level.
   localparam int CHANNELS_DEF = 2;

   // Field and register widths.
   localparam int SAMPLE_W = 24;
   localparam int LEVELS_W = 24;
   localparam int INV_W    = 25;
   localparam int STEP_W   = 26;
   localparam int GAIN_W   = 16;

   // Configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 26;

   localparam logic [CSR_ADDR_W-1:0] REG_QUANT_LEVELS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INV_LEVELS   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_HOLD_STEP    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_OUT_GAIN     = 2'd3;

   // Register reset values.
   localparam logic [LEVELS_W-1:0] QUANT_LEVELS_RST = 24'd16776960;
   localparam logic [INV_W-1:0]    INV_LEVELS_RST   = 25'd256;
   localparam logic [STEP_W-1:0]   HOLD_STEP_RST    = 26'd65536;
   localparam logic [GAIN_W-1:0]   OUT_GAIN_RST     = 16'd16384;

   // One frame in the 10.16 hold counter.
   localparam logic [STEP_W-1:0] ONE_FRAME = 26'd65536;

   // Serial multiplier geometry: A is added in parallel, B is shifted out
   // one bit per cycle.
   localparam int MUL_A_W   = 25;
   localparam int MUL_B_W   = 24;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = 5;

   // Number of multiplier bits consumed by each product.
   localparam logic [MUL_CNT_W-1:0] STEPS_LEVEL = 5'd24;
   localparam logic [MUL_CNT_W-1:0] STEPS_INV   = 5'd17;
   localparam logic [MUL_CNT_W-1:0] STEPS_GAIN  = 5'd16;

   // Saturation limits of a Q1.23 value.
   localparam logic [SAMPLE_W-1:0] SAT_POS = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] SAT_NEG = 24'h800000;

   // Control from the top level to every lane.
   typedef struct packed {
      logic start;
      logic refresh;
      logic ack;
   } lane_ctl_type;

   // Rounds a magnitude half away from zero, applies the sign and saturates
   // to Q1.23. The magnitude is given as the bits kept after the shift (hi),
   // the first bit shifted out (rbit) and an overflow flag for any kept bit
   // at or above 2^23.
   function automatic logic [SAMPLE_W-1:0] sat_round(
      input logic                ovf,
      input logic [SAMPLE_W-2:0] hi,
      input logic                rbit,
      input logic                neg
   );
      logic [SAMPLE_W-1:0] mag;
      logic [SAMPLE_W-1:0] res;
      mag = {1'b0, hi} + {{(SAMPLE_W-1){1'b0}}, rbit};
      if (ovf) begin
         res = neg ? SAT_NEG : SAT_POS;
      end else if (!neg && mag[SAMPLE_W-1]) begin
         res = SAT_POS;
      end else if (neg) begin
         res = ~mag + 1'b1;
      end else begin
         res = mag;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bit_crusher_sample_hold.sv -----
// One frame is in work at a time: a new frame is accepted only once the lanes have
// handed the last result to the output register. Each lane's bit-serial multiplier
// runs the level, reciprocal and gain products when the held values refresh, and
// only the gain product when they do not.
// The next frame is accepted while a finished result waits in the output register.
// Reset (synchronous) clears the hold counter and held values and loads register defaults.
// ----------------------------------------------------------------------------
// Bit crusher with sample-and-hold
// Quantizes each channel of a frame to the configured level count on every
// hold step, then applies the output gain with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_crusher_sample_hold import bcsh_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // left_in, right_in, ... (one 24-bit sample per channel, from bit 0 up)
   input  wire logic [CHANNELS*SAMPLE_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // left_out, right_out, ... (one 24-bit value per channel, from bit 0 up)
   output logic [CHANNELS*SAMPLE_W-1:0]        rsp_tdata,
   input  wire logic                           csr_wen,
   input  wire logic [CSR_ADDR_W-1:0]          csr_addr,
   input  wire logic [CSR_DATA_W-1:0]          csr_wdata
);

   logic [LEVELS_W-1:0] quant_levels_ff, quant_levels_in;
   logic [INV_W-1:0]    inv_levels_ff, inv_levels_in;
   logic [STEP_W-1:0]   hold_step_ff, hold_step_in;
   logic [GAIN_W-1:0]   out_gain_ff, out_gain_in;

   logic [STEP_W-1:0]   hold_count_ff, hold_count_in;
   logic                busy_ff, busy_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [CHANNELS*SAMPLE_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                accept;
   logic                ack;
   logic [STEP_W-1:0]   step_eff;
   logic [STEP_W:0]     hold_sum;
   logic [STEP_W+1:0]   hold_diff;
   logic                refresh;
   lane_ctl_type        lane_ctl;
   logic [CHANNELS-1:0] lane_done;
   logic [CHANNELS*SAMPLE_W-1:0] lane_result;

   // Configuration register writes.
   always_comb begin
      quant_levels_in = quant_levels_ff;
      inv_levels_in   = inv_levels_ff;
      hold_step_in    = hold_step_ff;
      out_gain_in     = out_gain_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            REG_QUANT_LEVELS: quant_levels_in = csr_wdata[LEVELS_W-1:0];
            REG_INV_LEVELS:   inv_levels_in   = csr_wdata[INV_W-1:0];
            REG_HOLD_STEP:    hold_step_in    = csr_wdata[STEP_W-1:0];
            REG_OUT_GAIN:     out_gain_in     = csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Hold counter: gain one frame, refresh and wrap when the step is reached.
   assign step_eff  = (hold_step_ff < ONE_FRAME) ? ONE_FRAME : hold_step_ff;
   assign hold_sum  = {1'b0, hold_count_ff} + {1'b0, ONE_FRAME};
   assign hold_diff = {1'b0, hold_sum} - {2'b00, step_eff};
   assign refresh   = !hold_diff[STEP_W+1];

   always_comb begin
      hold_count_in = hold_count_ff;
      if (accept) begin
         hold_count_in = refresh ? hold_diff[STEP_W-1:0] : hold_sum[STEP_W-1:0];
      end
   end

   // Handshake: one frame in the lanes, one result in the output register.
   assign accept = req_tvalid && req_tready;
   assign ack    = busy_ff && (&lane_done) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      busy_in       = busy_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (ack) begin
         busy_in = 1'b0;
      end
      if (ack) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = lane_result;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   assign lane_ctl.start   = accept;
   assign lane_ctl.refresh = refresh;
   assign lane_ctl.ack     = ack;

   // One lane per channel, all running in lockstep.
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      bcsh_lane u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (lane_ctl),
         .sample       (req_tdata[c*SAMPLE_W +: SAMPLE_W]),
         .quant_levels (quant_levels_ff),
         .inv_levels   (inv_levels_ff),
         .out_gain     (out_gain_ff),
         .done         (lane_done[c]),
         .result       (lane_result[c*SAMPLE_W +: SAMPLE_W])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_levels_ff <= QUANT_LEVELS_RST;
         inv_levels_ff   <= INV_LEVELS_RST;
         hold_step_ff    <= HOLD_STEP_RST;
         out_gain_ff     <= OUT_GAIN_RST;
         hold_count_ff   <= '0;
         busy_ff         <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         quant_levels_ff <= quant_levels_in;
         inv_levels_ff   <= inv_levels_in;
         hold_step_ff    <= hold_step_in;
         out_gain_ff     <= out_gain_in;
         hold_count_ff   <= hold_count_in;
         busy_ff         <= busy_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The lanes share one schedule, so they finish together.
   assert property (@(posedge clock) disable iff (reset)
      (|lane_done) |-> (&lane_done))
      else $error("lanes finished out of step");

   // A finished lane always belongs to a frame in work.
   assert property (@(posedge clock) disable iff (reset)
      (|lane_done) |-> busy_ff)
      else $error("lane result without a frame in work");

   // A waiting result is never overwritten by the next one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |-> !ack)
      else $error("output register overwritten");

   // A new frame never starts while lanes still hold a result.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> !(|lane_done))
      else $error("frame accepted over an unread lane result");

endmodule

`default_nettype wire

// ----- rtl/bcsh_smul.sv -----
// ----------------------------------------------------------------------------
// Bit crusher serial multiplier
// Unsigned shift-and-add multiplier: one bit of B per cycle, LSB first, with
// the partial product shifted right through the same register as B.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsh_smul import bcsh_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MUL_A_W-1:0]   a,
   input  wire logic [MUL_B_W-1:0]   b,
   input  wire logic [MUL_CNT_W-1:0] steps,
   output logic                      done,
   output logic [MUL_P_W-1:0]        product
);

   logic [MUL_A_W-1:0]   a_ff, a_in;
   logic [MUL_P_W-1:0]   p_ff, p_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MUL_A_W:0]     partial;

   // Add A into the upper half when the current multiplier bit is set.
   assign partial = {1'b0, p_ff[MUL_P_W-1:MUL_B_W]} +
                    (p_ff[0] ? {1'b0, a_ff} : {(MUL_A_W+1){1'b0}});

   // Load on start, then one shift-add step per cycle.
   always_comb begin
      a_in    = a_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         p_in   = {{MUL_A_W{1'b0}}, b};
         cnt_in = steps;
         run_in = 1'b1;
      end else if (run_ff) begin
         p_in   = {partial, p_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

// ----- rtl/bcsh_lane.sv -----
// ----------------------------------------------------------------------------
// Bit crusher channel lane
// Holds one channel's value and sequences its serial multiplier through the
// quantize and rescale products on a refresh, then the gain product.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsh_lane import bcsh_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lane_ctl_type        ctl,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic [LEVELS_W-1:0] quant_levels,
   input  wire logic [INV_W-1:0]    inv_levels,
   input  wire logic [GAIN_W-1:0]   out_gain,
   output logic                     done,
   output logic [SAMPLE_W-1:0]      result
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL1  = 3'd1;
   localparam logic [2:0] ST_MUL2  = 3'd2;
   localparam logic [2:0] ST_LOAD3 = 3'd3;
   localparam logic [2:0] ST_MUL3  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic [SAMPLE_W-1:0]  held_ff, held_in;
   logic [SAMPLE_W-1:0]  result_ff, result_in;

   logic                 mul_start;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [MUL_CNT_W-1:0] mul_steps;
   logic                 mul_done;
   logic [MUL_P_W-1:0]   p;

   logic [SAMPLE_W-1:0]  sample_mag;
   logic [SAMPLE_W-1:0]  held_mag;
   logic [16:0]          q_mag;
   logic [SAMPLE_W-1:0]  held_new;
   logic [SAMPLE_W-1:0]  out_new;

   bcsh_smul u_smul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .steps   (mul_steps),
      .done    (mul_done),
      .product (p)
   );

   // Magnitudes of the signed sample and of the held value.
   assign sample_mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
   assign held_mag   = held_ff[SAMPLE_W-1] ? (~held_ff + 1'b1) : held_ff;

   // Level: product is exact, divide by 2^31 with rounding.
   assign q_mag = p[47:31] + {16'd0, p[30]};

   // Held: the 17-step product sits 7 bits up; divide by 2 with rounding.
   assign held_new = sat_round(|p[48:31], p[30:8], p[7], neg_ff);

   // Output: the 16-step product sits 8 bits up; divide by 2^14 with rounding.
   assign out_new = sat_round(|p[48:45], p[44:22], p[21], held_ff[SAMPLE_W-1]);

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      held_in   = held_ff;
      result_in = result_ff;
      mul_start = 1'b0;
      mul_a     = {1'b0, quant_levels};
      mul_b     = sample_mag;
      mul_steps = STEPS_LEVEL;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               neg_in = sample[SAMPLE_W-1];
               if (ctl.refresh) begin
                  mul_start = 1'b1;
                  state_in  = ST_MUL1;
               end else begin
                  state_in = ST_LOAD3;
               end
            end
         end
         ST_MUL1: begin
            mul_a     = inv_levels;
            mul_b     = {7'd0, q_mag};
            mul_steps = STEPS_INV;
            if (mul_done) begin
               mul_start = 1'b1;
               state_in  = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mul_done) begin
               held_in  = held_new;
               state_in = ST_LOAD3;
            end
         end
         ST_LOAD3: begin
            mul_a     = {1'b0, held_mag};
            mul_b     = {8'd0, out_gain};
            mul_steps = STEPS_GAIN;
            mul_start = 1'b1;
            state_in  = ST_MUL3;
         end
         ST_MUL3: begin
            if (mul_done) begin
               result_in = out_new;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ctl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done   = (state_ff == ST_DONE);
   assign result = result_ff;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit crusher sample-and-hold testbench
// Streams stereo frames through the block under a series of register
// settings. Each accepted frame is run through a local fixed-point predictor,
// and the returned beats are checked field by field against it.
// ----------------------------------------------------------------------------

module tb_top;
   import bcsh_pkg::*;

   localparam int FRAME_W = 2 * SAMPLE_W;
   localparam int unsigned STALL_LIMIT     = 3000;
   localparam int unsigned SETTLE_CYCLES   = 80;
   localparam int unsigned PRESSURE_CYCLES = 400;
   localparam int unsigned RANDOM_PHASES   = 12;
   localparam int unsigned PHASE_FRAMES    = 60;
   localparam longint Q23_MAX = 8388607;
   localparam longint Q23_MIN = -8388608;

   // One stereo frame, left channel in the low bits.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] right_smp;
      logic signed [SAMPLE_W-1:0] left_smp;
   } stereo_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // left_in, right_in
   logic [FRAME_W-1:0]    req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // left_out, right_out
   logic [FRAME_W-1:0]    rsp_tdata;
   logic                  csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Predictor copy of the registers and the hold state.
   logic [LEVELS_W-1:0]        cfg_levels = QUANT_LEVELS_RST;
   logic [INV_W-1:0]           cfg_inv    = INV_LEVELS_RST;
   logic [STEP_W-1:0]          cfg_step   = HOLD_STEP_RST;
   logic [GAIN_W-1:0]          cfg_gain   = OUT_GAIN_RST;
   logic [STEP_W-1:0]          hold_count = '0;
   logic signed [SAMPLE_W-1:0] held_smp [2] = '{default: '0};

   stereo_type frame_q [$];
   stereo_type crushed_q [$];

   logic        req_beat = 1'b0;
   logic        rsp_beat = 1'b0;
   logic        burst_mode = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rx_gap = 0;
   int unsigned rx_hold = 0;
   int unsigned rsp_beats = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;

   bit_crusher_sample_hold dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Divides by 2^sh with rounding half away from zero.
   function automatic longint round_away(input longint p, input int sh);
      longint mag;
      mag = (p < 0) ? -p : p;
      mag = (mag + (longint'(1) << (sh - 1))) >> sh;
      return (p < 0) ? -mag : mag;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clip_q23(input longint v);
      if (v > Q23_MAX) return SAT_POS;
      if (v < Q23_MIN) return SAT_NEG;
      return v[SAMPLE_W-1:0];
   endfunction

   // Advances the hold counter, refreshes the held levels when the step is
   // reached, and returns the gained output of one frame.
   function automatic stereo_type crush_frame(input stereo_type frame);
      logic [31:0] step;
      logic [31:0] count;
      logic        refresh;
      longint      smp;
      longint      level;
      longint      held;
      stereo_type  res;
      step = (cfg_step < ONE_FRAME) ? 32'(ONE_FRAME) : 32'(cfg_step);
      count = 32'(hold_count) + 32'(ONE_FRAME);
      refresh = (count >= step);
      if (refresh) count = count - step;
      hold_count = count[STEP_W-1:0];
      for (int ch = 0; ch < 2; ch++) begin
         if (refresh) begin
            smp = (ch == 0) ? frame.left_smp : frame.right_smp;
            level = round_away(smp * longint'({40'd0, cfg_levels}), 31);
            held_smp[ch] = clip_q23(round_away(level * longint'({39'd0, cfg_inv}), 1));
         end
         held = held_smp[ch];
         held = clip_q23(round_away(held * longint'({48'd0, cfg_gain}), 14));
         if (ch == 0) res.left_smp = held[SAMPLE_W-1:0];
         else res.right_smp = held[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   // Idle length between beats: mostly none or short, now and then long.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 24);
      return $urandom_range(40, 200);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 6) return SAT_POS;
      if (r < 12) return SAT_NEG;
      if (r < 25) return SAMPLE_W'($urandom_range(0, 64)) - 24'd32;
      return SAMPLE_W'($urandom);
   endfunction

   // Register writes happen only while no frame is in flight, so the
   // predictor copy is updated right away.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         REG_QUANT_LEVELS: cfg_levels = val[LEVELS_W-1:0];
         REG_INV_LEVELS:   cfg_inv    = val[INV_W-1:0];
         REG_HOLD_STEP:    cfg_step   = val[STEP_W-1:0];
         REG_OUT_GAIN:     cfg_gain   = val[GAIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // Programs a consistent level count and reciprocal for the given bit depth.
   task automatic set_crush(input int bits, input logic [STEP_W-1:0] step,
                            input logic [GAIN_W-1:0] gain);
      longint lv;
      lv = (longint'(1) << bits) - 1;
      write_reg(REG_QUANT_LEVELS, CSR_DATA_W'(lv << 8));
      write_reg(REG_INV_LEVELS, CSR_DATA_W'(((longint'(1) << 24) + lv / 2) / lv));
      write_reg(REG_HOLD_STEP, step);
      write_reg(REG_OUT_GAIN, CSR_DATA_W'(gain));
   endtask

   task automatic add_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
      frame_q.push_back({r, l});
   endtask

   // Waits until every frame is sent and answered, then lets the block settle.
   task automatic wait_idle();
      while (frame_q.size() != 0 || req_tvalid || crushed_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Frame driver: holds a beat until accepted, then idles or sends the next.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_beat) begin
         req_tvalid <= 1'b1;
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (frame_q.size() > 0) begin
         req_tdata  <= frame_q.pop_front();
         req_tvalid <= 1'b1;
         req_gap = idle_len();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result receiver: random stalls, plus two long hold-offs that back the
   // block up into its input.
   always @(negedge clock) begin
      if (rsp_beat) begin
         rsp_beats++;
         if (rsp_beats == 100 || rsp_beats == 450) rx_hold = PRESSURE_CYCLES;
         else rx_gap = idle_len();
      end
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts each accepted frame and checks each result beat.
   always @(posedge clock) begin
      stereo_type got;
      stereo_type want;
      req_beat = !reset && req_tvalid && req_tready;
      rsp_beat = !reset && rsp_tvalid && rsp_tready;
      if (rsp_beat) begin
         got = rsp_tdata;
         if (crushed_q.size() == 0) begin
            $display("%0t: result beat with nothing expected: left_out %0d right_out %0d",
                     $time, got.left_smp, got.right_smp);
            mismatches++;
         end else begin
            want = crushed_q.pop_front();
            if (got.left_smp !== want.left_smp) begin
               $display("%0t: left_out mismatch: expected %0d, actual %0d",
                        $time, want.left_smp, got.left_smp);
               mismatches++;
            end
            if (got.right_smp !== want.right_smp) begin
               $display("%0t: right_out mismatch: expected %0d, actual %0d",
                        $time, want.right_smp, got.right_smp);
               mismatches++;
            end
         end
      end
      if (req_beat) crushed_q.push_back(crush_frame(req_tdata));
   end

   // Watchdog on cycles without any beat or register write.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned r;
      int          bits;
      logic [STEP_W-1:0] step;
      logic [GAIN_W-1:0] gain;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults: extremes, signs and a mid-scale value.
      add_frame(24'd0, 24'd0);
      add_frame(SAT_POS, SAT_NEG);
      add_frame(SAT_NEG, SAT_POS);
      add_frame(24'd1, -24'sd1);
      add_frame(-24'sd1, 24'd1);
      add_frame(24'h400000, -24'sh400000);
      wait_idle();

      // One-bit crush at a gain of two: exact halfway levels round away from zero.
      set_crush(1, ONE_FRAME, 16'd32768);
      add_frame(24'h400000, -24'sh400000);
      add_frame(24'h3FFFFF, -24'sh3FFFFF);
      add_frame(SAT_POS, SAT_NEG);
      add_frame(24'h400001, 24'd0);
      wait_idle();

      // Gain above two saturates; a step below one frame refreshes every frame.
      set_crush(8, '0, 16'hFFFF);
      add_frame(SAT_POS, SAT_NEG);
      add_frame(24'h123456, -24'sh123456);
      add_frame(24'd0, 24'd1);
      wait_idle();

      // Finest levels, longest step, zero gain.
      set_crush(16, {STEP_W{1'b1}}, 16'd0);
      add_frame(SAT_NEG, 24'h0ABCDE);
      add_frame(24'h7F0000, SAT_POS);
      wait_idle();

      // Count up against a long step, then lower it so the counter catches up.
      set_crush(4, 26'd655360, 16'd16384);
      repeat (3) add_frame(pick_sample(), pick_sample());
      wait_idle();
      write_reg(REG_HOLD_STEP, 26'd98304);
      repeat (6) add_frame(pick_sample(), pick_sample());
      wait_idle();

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         bits = $urandom_range(1, 16);
         r = $urandom_range(0, 9);
         if (r < 4) step = ONE_FRAME;
         else if (r < 7) step = STEP_W'($urandom_range(65536, 4 * 65536));
         else if (r < 9) step = STEP_W'($urandom_range(65536, 16 * 65536));
         else step = STEP_W'($urandom_range(0, 65535));
         r = $urandom_range(0, 9);
         if (r < 2) gain = 16'd16384;
         else if (r < 9) gain = GAIN_W'($urandom_range(0, 32768));
         else gain = GAIN_W'($urandom_range(32769, 65535));
         set_crush(bits, step, gain);
         // Now and then the level count and reciprocal disagree.
         if ($urandom_range(0, 5) == 0) begin
            write_reg(REG_QUANT_LEVELS, CSR_DATA_W'($urandom));
            write_reg(REG_INV_LEVELS, CSR_DATA_W'($urandom));
         end
         burst_mode = ($urandom_range(0, 3) == 0);
         repeat (PHASE_FRAMES) add_frame(pick_sample(), pick_sample());
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- bit_crusher_sample_hold.f -----
rtl/bcsh_pkg.sv
rtl/bcsh_smul.sv
rtl/bcsh_lane.sv
rtl/bit_crusher_sample_hold.sv
tb/tb_top.sv
